/* design/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// No dependencies; the screen memory, sequencer and top-level files import this package.
package tcw_pkg;

    // Default geometry
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Character and attribute codes
    localparam logic [7:0] BG_RESET    = 8'h07;
    localparam logic [7:0] BLANK_CHAR  = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [7:0] color_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic [7:0] char_color;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } req_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic [4:0] cursor_row;
        logic [6:0] cursor_column;
    } rsp_item_t;

    // Screen cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] code;
    } cell_t;

    // Screen memory strobes
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

/* design/tcw_stream_if.sv */
// Valid/ready channel carrying one payload per transfer.
// Payload type is set per instance; used for request, response and config.
interface tcw_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tcw_screen_ram.sv */
// Screen cell memory: one port, write or registered read per cycle.
// Depends on tcw_pkg.
module tcw_screen_ram #(
    parameter int  DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLUMNS_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  tcw_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]    addr,
    input  tcw_pkg::cell_t   wdata,
    output tcw_pkg::cell_t   rdata
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tcw_ctrl.sv */
// Sequencer for the console: clear pass, cursor update, cell writes,
// scroll blanking and cell reads against the screen memory. Depends on tcw_pkg.
module tcw_ctrl #(
    parameter int  COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS     = tcw_pkg::ROWS_DEF,
    parameter int  TAB_STOP = tcw_pkg::TAB_STOP_DEF,
    localparam int AW       = $clog2(ROWS * COLUMNS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcw_pkg::req_item_t in_item,
    input  tcw_pkg::color_t    bg_color,
    output logic               res_valid,
    input  logic               res_ready,
    output tcw_pkg::rsp_item_t res_item,
    output tcw_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]      mem_addr,
    output tcw_pkg::cell_t     mem_wdata,
    input  tcw_pkg::cell_t     mem_rdata
);
    import tcw_pkg::*;

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLUMNS);
    localparam int CXW = $clog2(COLUMNS + TAB_STOP);
    localparam int TW  = $clog2(TAB_STOP);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDATA  = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]    state_reg, state_next;
    req_item_t     item_reg, item_next;
    logic [RW-1:0] top_reg, top_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [TW-1:0] phase_reg, phase_next;     // column modulo tab stop
    logic [CW-1:0] blank_cnt_reg, blank_cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] base_reg, base_next;
    logic          hit_reg, hit_next;

    logic          printable, is_tab, is_nl;
    logic [CXW-1:0] col_wide;
    logic [TW-1:0] phase_adv;
    logic          wrap, row_inc, scroll;
    logic [RW:0]   phys_w_sum, phys_r_sum;
    logic [RW-1:0] phys_w, phys_r;
    logic          row_ok, col_ok;

    function automatic logic [AW-1:0] row_base(input logic [RW-1:0] r);
        return AW'(r) * AW'(COLUMNS);
    endfunction

    // Ring-mapped physical rows for the cursor and for the read address
    always_comb
    begin
        phys_w_sum = {1'b0, top_reg} + {1'b0, row_reg};
        phys_r_sum = {1'b0, top_reg} + (RW+1)'(item_reg.read_row);
        phys_w = (phys_w_sum >= (RW+1)'(ROWS)) ? RW'(phys_w_sum - (RW+1)'(ROWS))
                                                : RW'(phys_w_sum);
        phys_r = (phys_r_sum >= (RW+1)'(ROWS)) ? RW'(phys_r_sum - (RW+1)'(ROWS))
                                                : RW'(phys_r_sum);
        row_ok = 32'(item_reg.read_row) < 32'(ROWS);
        col_ok = 32'(item_reg.read_column) < 32'(COLUMNS);
    end

    // Cursor arithmetic for a write
    always_comb
    begin
        printable = (item_reg.char_code >= PRINT_LO) && (item_reg.char_code <= PRINT_HI);
        is_tab    = item_reg.char_code == CHAR_TAB;
        is_nl     = item_reg.char_code == CHAR_NL;
        phase_adv = phase_reg;
        col_wide  = CXW'(col_reg);
        if (printable)
        begin
            col_wide  = CXW'(col_reg) + CXW'(1);
            phase_adv = (phase_reg == TW'(TAB_STOP - 1)) ? '0 : phase_reg + TW'(1);
        end
        else if (is_tab)
        begin
            col_wide  = CXW'(col_reg) + CXW'(TAB_STOP) - CXW'(phase_reg);
            phase_adv = '0;
        end
        else if (is_nl)
        begin
            col_wide  = '0;
            phase_adv = '0;
        end
        wrap    = col_wide >= CXW'(COLUMNS);
        row_inc = is_nl || wrap;
        scroll  = row_inc && (row_reg == RW'(ROWS - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        top_next       = top_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        blank_cnt_next = blank_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        base_next      = base_reg;
        hit_next       = hit_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_ctl        = '0;
        mem_addr       = '0;
        mem_wdata      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.we = 1'b1;
                mem_addr   = clr_addr_reg;
                mem_wdata  = '{color: BG_RESET, code: BLANK_CHAR};
                if (clr_addr_reg == AW'(ROWS * COLUMNS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (item_reg.command == CMD_READ)
                begin
                    if (row_ok && col_ok)
                    begin
                        mem_ctl.re = 1'b1;
                        mem_addr   = row_base(phys_r) + AW'(item_reg.read_column);
                        hit_next   = 1'b1;
                        state_next = S_RDATA;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    hit_next   = 1'b0;
                    mem_ctl.we = printable;
                    mem_addr   = row_base(phys_w) + AW'(col_reg);
                    mem_wdata  = '{color: item_reg.char_color, code: item_reg.char_code};
                    col_next   = wrap ? '0 : CW'(col_wide);
                    phase_next = wrap ? '0 : phase_adv;
                    if (scroll)
                    begin
                        base_next      = row_base(top_reg);
                        blank_cnt_next = '0;
                        state_next     = S_SCROLL;
                    end
                    else
                    begin
                        if (row_inc)
                        begin
                            row_next = row_reg + RW'(1);
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_RDATA:
            begin
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                // blank the old top row, which becomes the new bottom row
                mem_ctl.we = 1'b1;
                mem_addr   = base_reg + AW'(blank_cnt_reg);
                mem_wdata  = '{color: bg_color, code: BLANK_CHAR};
                if (blank_cnt_reg == CW'(COLUMNS - 1))
                begin
                    blank_cnt_next = '0;
                    top_next   = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    blank_cnt_next = blank_cnt_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // rdata holds from the read until the result is handed over
    always_comb
    begin
        res_item.cell_char     = hit_reg ? mem_rdata.code : 8'h00;
        res_item.cell_color    = hit_reg ? mem_rdata.color : 8'h00;
        res_item.cursor_row    = 5'(row_reg);
        res_item.cursor_column = 7'(col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            top_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            blank_cnt_reg <= '0;
            clr_addr_reg  <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            blank_cnt_reg <= blank_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        base_reg <= base_next;
    end

endmodule

/* design/text_console_writer_unit.sv */
// Text console writer: one item in flight; a write steps through the exec and done
// states, an in-range read also through rdata, and a write that scrolls also blanks
// one row (one memory write per cell) before done.
// Reset (rst_n, async, active low) clears cursor, ring pointer and output valid, then
// a clearing pass writes all ROWS*COLUMNS cells with req.ready low.
// Depends on tcw_pkg, tcw_stream_if, tcw_screen_ram and tcw_ctrl.
module text_console_writer_unit #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input logic          clk,
    input logic          rst_n,
    tcw_stream_if.sink   req,
    tcw_stream_if.source rsp,
    tcw_stream_if.sink   cfg
);
    import tcw_pkg::*;

    localparam int AW = $clog2(ROWS * COLUMNS);

    // Background attribute register; the port takes a transfer every cycle.
    color_t bg_color_reg;

    // Handoff between sequencer and the response register
    logic      res_valid;
    logic      res_ready;
    rsp_item_t res_item;

    // Screen memory port
    mem_ctl_t      mem_ctl;
    logic [AW-1:0] mem_addr;
    cell_t         mem_wdata;
    cell_t         mem_rdata;

    // Response register: parts the sequencer from the downstream stall
    logic      rsp_valid_reg;
    rsp_item_t rsp_data_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_color_reg <= BG_RESET;
        end
        else if (cfg.valid)
        begin
            bg_color_reg <= cfg.data;
        end
    end

    tcw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (req.data),
        .bg_color  (bg_color_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (ROWS * COLUMNS)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // A new result may land when the slot is empty or is being emptied.
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res_item;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // One item in flight: an accepted transfer closes the request side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while an item is in flight");

    // A blocked result keeps its value until the response slot frees up.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("pending result changed or dropped");

    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 32'(rsp.data.cursor_column) < 32'(COLUMNS))
        else $error("cursor column out of range");

    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 32'(rsp.data.cursor_row) < 32'(ROWS))
        else $error("cursor row out of range");

endmodule
